// ===== sv/delta_frame_bit_decoder_core_macros.svh =====
// Assertion macros for the delta frame bit decoder checker.
// No dependencies; included by the checker file only.
`ifndef DELTA_FRAME_BIT_DECODER_CORE_MACROS_SVH
`define DELTA_FRAME_BIT_DECODER_CORE_MACROS_SVH

// Property checked at every clock edge outside reset
`define DFBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in this cycle, consequent in the next one
`define DFBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dfbd_pkg.sv =====
// Shared constants and types of the delta frame bit decoder.
// No dependencies; used by every RTL file of the block but dfbd_ram.
package dfbd_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int POS_W       = IDX_W + 1;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 32;
    localparam int SEEN_W      = 4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Field widths of the parser phases
    localparam logic [SEEN_W-1:0] TYPE_BITS  = SEEN_W'(2);
    localparam logic [SEEN_W-1:0] COUNT_BITS = SEEN_W'(IDX_W);
    localparam logic [SEEN_W-1:0] BYTE_BITS  = SEEN_W'(BYTE_W);

    // Frame type codes
    localparam logic [1:0] FT_REPEAT = 2'b00;
    localparam logic [1:0] FT_RLE    = 2'b01;
    localparam logic [1:0] FT_INDEX  = 2'b10;
    localparam logic [1:0] FT_PLAIN  = 2'b11;

    // Request codes on the input channel
    localparam logic REQ_BIT     = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Result status codes
    localparam logic ST_FRAME = 1'b0;
    localparam logic ST_TRUNC = 1'b1;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TOTAL_BITS = 1'b0;

    // Parser to emitter requests
    typedef struct packed {
        logic restart;
        logic frame;
        logic trunc;
    } emit_req_t;

    // Emitter status back to the parser
    typedef struct packed {
        logic busy;
    } emit_stat_t;

    // Emitter read port into the difference memory
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] addr;
    } diff_rd_t;

endpackage

// ===== sv/dfbd_stream_if.sv =====
// Valid/ready channel interfaces of the delta frame bit decoder.
// Depends on dfbd_pkg for field widths.
interface dfbd_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic stream_bit;

    modport source (output valid, output req_type, output stream_bit, input ready);
    modport sink   (input valid, input req_type, input stream_bit, output ready);
endinterface

interface dfbd_out_if;
    logic                             valid;
    logic                             ready;
    logic [dfbd_pkg::BYTE_W-1:0]      byte_value;
    logic [dfbd_pkg::IDX_W-1:0]       byte_index;
    logic                             frame_last;
    logic                             status;

    modport source (output valid, output byte_value, output byte_index,
                    output frame_last, output status, input ready);
    modport sink   (input valid, input byte_value, input byte_index,
                    input frame_last, input status, output ready);
endinterface

// ===== sv/dfbd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dfbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/dfbd_apb.sv =====
// APB register block: holds the total_bits register.
// Depends on dfbd_pkg.
module dfbd_apb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dfbd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dfbd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dfbd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [dfbd_pkg::CNT_W-1:0]       total_bits
);

    logic [dfbd_pkg::CNT_W-1:0] total_bits_reg;
    logic                       wr_hit;

    // Register index is the word address
    assign wr_hit = psel && penable && pwrite && pready &&
                    (paddr[dfbd_pkg::APB_ADDR_W-1] == dfbd_pkg::REG_TOTAL_BITS);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bits_reg <= '0;
        end
        else if (wr_hit)
        begin
            total_bits_reg <= pwdata;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[dfbd_pkg::APB_ADDR_W-1])
            dfbd_pkg::REG_TOTAL_BITS: prdata = total_bits_reg;
            default:                  prdata = '0;
        endcase
    end

    assign total_bits = total_bits_reg;

endmodule

// ===== sv/dfbd_parser.sv =====
// Bit parser: shifts stream bits into fields and builds the difference frame
// in a RAM with per-entry valid bits. Depends on dfbd_pkg, dfbd_stream_if, dfbd_ram.
module dfbd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    dfbd_in_if.sink                     in_ch,
    input  logic [dfbd_pkg::CNT_W-1:0]  total_bits,
    output dfbd_pkg::emit_req_t         req,
    input  dfbd_pkg::emit_stat_t        stat,
    input  dfbd_pkg::diff_rd_t          rd,
    output logic [dfbd_pkg::BYTE_W-1:0] diff_byte
);

    typedef enum logic [1:0] {P_RUN, P_FILL, P_WAIT} pstate_t;
    typedef enum logic [2:0] {
        PH_TYPE, PH_RLE_COUNT, PH_RLE_BYTE, PH_IDX_COUNT,
        PH_IDX_POS, PH_IDX_BYTE, PH_PLAIN
    } phase_t;

    pstate_t                            state_reg, state_next;
    phase_t                             phase_reg, phase_next;
    logic [dfbd_pkg::BYTE_W-1:0]        shift_reg, shift_next;
    logic [dfbd_pkg::SEEN_W-1:0]        seen_reg, seen_next;
    logic [dfbd_pkg::POS_W-1:0]         fill_reg, fill_next;
    logic [dfbd_pkg::POS_W-1:0]         entries_reg, entries_next;
    logic [dfbd_pkg::IDX_W-1:0]         held_reg, held_next;
    logic [dfbd_pkg::BYTE_W-1:0]        run_byte_reg, run_byte_next;
    logic [dfbd_pkg::CNT_W-1:0]         bc_reg, bc_next;
    logic [dfbd_pkg::FRAME_BYTES-1:0]   dvalid_reg, dvalid_next;
    logic                               dv_rd_reg;

    logic                               acc;
    logic                               wr_en;
    logic [dfbd_pkg::IDX_W-1:0]         wr_addr;
    logic [dfbd_pkg::BYTE_W-1:0]        wr_data;
    logic [dfbd_pkg::BYTE_W-1:0]        ram_q;

    assign in_ch.ready = (state_reg == P_RUN);
    assign acc         = in_ch.valid && in_ch.ready;

    // Next-state and field decode
    always_comb
    begin
        logic [dfbd_pkg::BYTE_W-1:0] sh;
        logic [dfbd_pkg::SEEN_W-1:0] sn;
        logic [dfbd_pkg::SEEN_W-1:0] wsel;
        logic [dfbd_pkg::POS_W-1:0]  fill_inc;
        logic [dfbd_pkg::POS_W-1:0]  ent_dec;
        logic                        done;
        logic                        to_fill;
        logic                        clr;

        state_next    = state_reg;
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        seen_next     = seen_reg;
        fill_next     = fill_reg;
        entries_next  = entries_reg;
        held_next     = held_reg;
        run_byte_next = run_byte_reg;
        bc_next       = bc_reg;
        dvalid_next   = dvalid_reg;
        req           = '0;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[dfbd_pkg::IDX_W-1:0];
        wr_data       = run_byte_reg;

        sh       = {shift_reg[dfbd_pkg::BYTE_W-2:0], in_ch.stream_bit};
        sn       = seen_reg + 1'b1;
        fill_inc = fill_reg + 1'b1;
        ent_dec  = entries_reg - 1'b1;
        done     = 1'b0;
        to_fill  = 1'b0;
        clr      = 1'b0;

        unique case (phase_reg)
            PH_TYPE:                             wsel = dfbd_pkg::TYPE_BITS;
            PH_RLE_COUNT, PH_IDX_COUNT, PH_IDX_POS: wsel = dfbd_pkg::COUNT_BITS;
            default:                             wsel = dfbd_pkg::BYTE_BITS;
        endcase

        unique case (state_reg)
            P_RUN:
            begin
                if (acc && (in_ch.req_type == dfbd_pkg::REQ_RESTART))
                begin
                    clr         = 1'b1;
                    bc_next     = '0;
                    dvalid_next = '0;
                    req.restart = 1'b1;
                end
                else if (acc && (bc_reg < total_bits))
                begin
                    bc_next = bc_reg + 1'b1;
                    if (sn >= wsel)
                    begin
                        shift_next = '0;
                        seen_next  = '0;
                        unique case (phase_reg)
                            PH_TYPE:
                            begin
                                dvalid_next = '0;
                                fill_next   = '0;
                                unique case (sh[1:0])
                                    dfbd_pkg::FT_REPEAT: done       = 1'b1;
                                    dfbd_pkg::FT_RLE:    phase_next = PH_RLE_COUNT;
                                    dfbd_pkg::FT_INDEX:  phase_next = PH_IDX_COUNT;
                                    default:             phase_next = PH_PLAIN;
                                endcase
                            end
                            PH_RLE_COUNT:
                            begin
                                entries_next = {1'b0, sh[dfbd_pkg::IDX_W-1:0]} + 1'b1;
                                phase_next   = PH_RLE_BYTE;
                            end
                            PH_RLE_BYTE:
                            begin
                                // Run is written one entry a cycle
                                run_byte_next = sh;
                                phase_next    = PH_RLE_COUNT;
                                to_fill       = 1'b1;
                            end
                            PH_IDX_COUNT:
                            begin
                                entries_next = {1'b0, sh[dfbd_pkg::IDX_W-1:0]} + 1'b1;
                                phase_next   = PH_IDX_POS;
                            end
                            PH_IDX_POS:
                            begin
                                held_next  = sh[dfbd_pkg::IDX_W-1:0];
                                phase_next = PH_IDX_BYTE;
                            end
                            PH_IDX_BYTE:
                            begin
                                wr_en   = 1'b1;
                                wr_addr = held_reg;
                                wr_data = sh;
                                dvalid_next[held_reg] = 1'b1;
                                if (entries_reg != '0)
                                begin
                                    entries_next = ent_dec;
                                end
                                if ((entries_reg == '0) || (ent_dec == '0))
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_IDX_POS;
                                end
                            end
                            default:
                            begin
                                // Plain bytes fill in order
                                if (!fill_reg[dfbd_pkg::POS_W-1])
                                begin
                                    wr_en     = 1'b1;
                                    wr_data   = sh;
                                    dvalid_next[fill_reg[dfbd_pkg::IDX_W-1:0]] = 1'b1;
                                    fill_next = fill_inc;
                                    done      = fill_inc[dfbd_pkg::POS_W-1];
                                end
                                else
                                begin
                                    done = 1'b1;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        shift_next = sh;
                        seen_next  = sn;
                    end

                    if (done)
                    begin
                        clr        = 1'b1;
                        req.frame  = 1'b1;
                        state_next = P_WAIT;
                    end
                    else if (to_fill)
                    begin
                        state_next = P_FILL;
                    end
                    else if (bc_next == total_bits)
                    begin
                        clr        = 1'b1;
                        req.trunc  = 1'b1;
                        state_next = P_WAIT;
                    end
                end
            end
            P_FILL:
            begin
                if ((entries_reg != '0) && !fill_reg[dfbd_pkg::POS_W-1])
                begin
                    wr_en        = 1'b1;
                    dvalid_next[fill_reg[dfbd_pkg::IDX_W-1:0]] = 1'b1;
                    fill_next    = fill_inc;
                    entries_next = ent_dec;
                end
                else if (fill_reg[dfbd_pkg::POS_W-1])
                begin
                    clr        = 1'b1;
                    req.frame  = 1'b1;
                    state_next = P_WAIT;
                end
                else if (bc_reg == total_bits)
                begin
                    clr        = 1'b1;
                    req.trunc  = 1'b1;
                    state_next = P_WAIT;
                end
                else
                begin
                    state_next = P_RUN;
                end
            end
            P_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = P_RUN;
                end
            end
            default:
            begin
                state_next = P_RUN;
            end
        endcase

        // Back to waiting for type bits
        if (clr)
        begin
            phase_next   = PH_TYPE;
            shift_next   = '0;
            seen_next    = '0;
            fill_next    = '0;
            entries_next = '0;
            held_next    = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= P_RUN;
            phase_reg   <= PH_TYPE;
            shift_reg   <= '0;
            seen_reg    <= '0;
            fill_reg    <= '0;
            entries_reg <= '0;
            held_reg    <= '0;
            bc_reg      <= '0;
            dvalid_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            seen_reg    <= seen_next;
            fill_reg    <= fill_next;
            entries_reg <= entries_next;
            held_reg    <= held_next;
            bc_reg      <= bc_next;
            dvalid_reg  <= dvalid_next;
        end
    end

    // Run byte and valid bit of the entry being read
    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
        if (rd.re)
        begin
            dv_rd_reg <= dvalid_reg[rd.addr];
        end
    end

    dfbd_ram #(
        .WIDTH (dfbd_pkg::BYTE_W),
        .DEPTH (dfbd_pkg::FRAME_BYTES)
    ) u_diff_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd.re),
        .raddr (rd.addr),
        .rdata (ram_q)
    );

    // Entries not written since the frame start read as zero
    assign diff_byte = dv_rd_reg ? ram_q : '0;

endmodule

// ===== sv/dfbd_emitter.sv =====
// Frame emitter: reads last and difference bytes, adds them, writes the sum
// back to the last-frame RAM and drives the result register.
// Depends on dfbd_pkg, dfbd_stream_if, dfbd_ram.
module dfbd_emitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfbd_pkg::emit_req_t         req,
    output dfbd_pkg::emit_stat_t        stat,
    output dfbd_pkg::diff_rd_t          rd,
    input  logic [dfbd_pkg::BYTE_W-1:0] diff_byte,
    dfbd_out_if.source                  out_ch
);

    typedef enum logic [1:0] {E_IDLE, E_FRAME, E_TRUNC} estate_t;

    estate_t                          state_reg;
    logic [dfbd_pkg::POS_W-1:0]       rd_cnt_reg;
    logic                             pend_reg;
    logic [dfbd_pkg::IDX_W-1:0]       pend_idx_reg;
    logic [dfbd_pkg::FRAME_BYTES-1:0] lvalid_reg;
    logic                             lv_rd_reg;
    logic                             out_valid_reg;
    logic [dfbd_pkg::BYTE_W-1:0]      out_value_reg;
    logic [dfbd_pkg::IDX_W-1:0]       out_index_reg;
    logic                             out_last_reg;
    logic                             out_status_reg;

    logic                             slot_free;
    logic                             consume;
    logic                             issue;
    logic                             trunc_load;
    logic [dfbd_pkg::BYTE_W-1:0]      last_q;
    logic [dfbd_pkg::BYTE_W-1:0]      last_byte;
    logic [dfbd_pkg::BYTE_W-1:0]      sum;

    // Read one entry ahead of the result register
    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign consume    = (state_reg == E_FRAME) && pend_reg && slot_free;
    assign issue      = (state_reg == E_FRAME) && !rd_cnt_reg[dfbd_pkg::POS_W-1] &&
                        (!pend_reg || consume);
    assign trunc_load = (state_reg == E_TRUNC) && slot_free;

    assign rd.re   = issue;
    assign rd.addr = rd_cnt_reg[dfbd_pkg::IDX_W-1:0];

    assign last_byte = lv_rd_reg ? last_q : '0;
    assign sum       = last_byte + diff_byte;

    assign stat.busy = (state_reg != E_IDLE);

    dfbd_ram #(
        .WIDTH (dfbd_pkg::BYTE_W),
        .DEPTH (dfbd_pkg::FRAME_BYTES)
    ) u_last_ram (
        .clk   (clk),
        .we    (consume),
        .waddr (pend_idx_reg),
        .wdata (sum),
        .re    (issue),
        .raddr (rd_cnt_reg[dfbd_pkg::IDX_W-1:0]),
        .rdata (last_q)
    );

    // Sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            lvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.restart)
            begin
                lvalid_reg <= '0;
            end

            unique case (state_reg)
                E_IDLE:
                begin
                    if (req.frame)
                    begin
                        state_reg  <= E_FRAME;
                        rd_cnt_reg <= '0;
                        pend_reg   <= 1'b0;
                    end
                    else if (req.trunc)
                    begin
                        state_reg <= E_TRUNC;
                    end
                end
                E_FRAME:
                begin
                    if (issue)
                    begin
                        rd_cnt_reg   <= rd_cnt_reg + 1'b1;
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= rd_cnt_reg[dfbd_pkg::IDX_W-1:0];
                    end
                    else if (consume)
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (consume)
                    begin
                        lvalid_reg[pend_idx_reg] <= 1'b1;
                        if (pend_idx_reg == dfbd_pkg::LAST_IDX)
                        begin
                            state_reg <= E_IDLE;
                        end
                    end
                end
                E_TRUNC:
                begin
                    if (slot_free)
                    begin
                        state_reg <= E_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase

            if (consume || trunc_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            lv_rd_reg <= lvalid_reg[rd_cnt_reg[dfbd_pkg::IDX_W-1:0]];
        end
        if (consume)
        begin
            out_value_reg  <= sum;
            out_index_reg  <= pend_idx_reg;
            out_last_reg   <= (pend_idx_reg == dfbd_pkg::LAST_IDX);
            out_status_reg <= dfbd_pkg::ST_FRAME;
        end
        else if (trunc_load)
        begin
            out_value_reg  <= '0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= dfbd_pkg::ST_TRUNC;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.byte_value = out_value_reg;
    assign out_ch.byte_index = out_index_reg;
    assign out_ch.frame_last = out_last_reg;
    assign out_ch.status     = out_status_reg;

endmodule

// ===== sv/delta_frame_bit_decoder_core.sv =====
// Channel | dir | payload
// in_ch   | in  | req_type, stream_bit (one bit or a restart per transaction)
// out_ch  | out | byte_value, byte_index, frame_last, status
// apb     | in  | total_bits at byte address 0
//
// One stream bit per cycle while a field is parsed; reset and restart clear both frame
// stores at once through per-entry valid bits.
// A run-length byte holds ready low for one difference RAM write per
// byte, clipped at the frame end, and then while the next step is picked.
// A finished frame holds ready low while its 32 entries are read, one per cycle unless
// out_ch stalls, plus the handoff; a truncation holds it low for handoff and stalls.
// Top level of the delta frame bit decoder. Depends on dfbd_pkg, dfbd_stream_if,
// dfbd_apb, dfbd_parser and dfbd_emitter.
module delta_frame_bit_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dfbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    dfbd_in_if.sink                         in_ch,
    dfbd_out_if.source                      out_ch
);

    logic [dfbd_pkg::CNT_W-1:0]  total_bits;
    dfbd_pkg::emit_req_t         req;
    dfbd_pkg::emit_stat_t        stat;
    dfbd_pkg::diff_rd_t          rd;
    logic [dfbd_pkg::BYTE_W-1:0] diff_byte;

    dfbd_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .total_bits (total_bits)
    );

    dfbd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .total_bits (total_bits),
        .req        (req),
        .stat       (stat),
        .rd         (rd),
        .diff_byte  (diff_byte)
    );

    dfbd_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .stat      (stat),
        .rd        (rd),
        .diff_byte (diff_byte),
        .out_ch    (out_ch)
    );

endmodule

// ===== sv/dfbd_checker.sv =====
// Port-level checker for the delta frame bit decoder, bound to the top level.
// Depends on dfbd_pkg and delta_frame_bit_decoder_core_macros.svh.
`include "delta_frame_bit_decoder_core_macros.svh"

module dfbd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_req_type,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dfbd_pkg::BYTE_W-1:0] out_value,
    input logic [dfbd_pkg::IDX_W-1:0]  out_index,
    input logic                        out_last,
    input logic                        out_status
);

    // A stalled result holds
    `DFBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_index) && $stable(out_last) && $stable(out_status), "stalled result changed")

    // Truncation result shape
    `DFBD_ASSERT(a_trunc_shape, clk, rst_n, (out_valid && (out_status == dfbd_pkg::ST_TRUNC)) |-> (out_last && (out_value == '0) && (out_index == '0)), "bad truncation result")

    // frame_last marks exactly the final byte of a frame
    `DFBD_ASSERT(a_frame_last, clk, rst_n, (out_valid && (out_status == dfbd_pkg::ST_FRAME)) |-> (out_last == (out_index == dfbd_pkg::LAST_IDX)), "frame_last misplaced")

    // A restart never starts a new result
    `DFBD_ASSERT_NEXT(a_restart_quiet, clk, rst_n, in_valid && in_ready && (in_req_type == dfbd_pkg::REQ_RESTART), !$rose(out_valid), "result after restart")

endmodule

bind delta_frame_bit_decoder_core dfbd_checker u_dfbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_value   (out_ch.byte_value),
    .out_index   (out_ch.byte_index),
    .out_last    (out_ch.frame_last),
    .out_status  (out_ch.status)
);

// ===== tb/dfbd_frame_checker.sv =====
// Frame checker for the delta frame bit decoder: watches the APB port and both
// channels, rebuilds the expected frame bytes and compares every output transaction.
// Depends on dfbd_pkg and the channel interfaces in dfbd_stream_if.
module dfbd_frame_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [dfbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfbd_pkg::APB_DATA_W-1:0] pwdata,
    dfbd_in_if                              in_mon,
    dfbd_out_if                             out_mon,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dfbd_pkg::APB_ADDR_W-1:0] TOTAL_ADDR = {dfbd_pkg::REG_TOTAL_BITS, 2'b00};

    // Parser position inside the current frame
    typedef enum logic [2:0] {
        P_TYPE,
        P_RUN_COUNT,
        P_RUN_BYTE,
        P_SPARSE_COUNT,
        P_SPARSE_POS,
        P_SPARSE_BYTE,
        P_PLAIN
    } phase_t;

    typedef struct packed {
        logic [dfbd_pkg::BYTE_W-1:0] value;
        logic [dfbd_pkg::IDX_W-1:0]  idx;
        logic                        is_last;
        logic                        status;
    } frame_byte_t;

    frame_byte_t       frame_bytes_due[$];

    // Decoder state as seen from outside
    logic [dfbd_pkg::BYTE_W-1:0] shown[dfbd_pkg::FRAME_BYTES];
    logic [dfbd_pkg::BYTE_W-1:0] delta[dfbd_pkg::FRAME_BYTES];
    phase_t                      phase;
    logic [dfbd_pkg::BYTE_W-1:0] shift_reg;
    int                          field_seen;
    int                          fill_pos;
    int                          runs_left;
    logic [dfbd_pkg::IDX_W-1:0]  target_idx;
    logic [31:0]                 bits_taken;
    logic [31:0]                 bit_budget;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int field_width(input phase_t ph);
        case (ph)
            P_TYPE:         return 2;
            P_RUN_COUNT,
            P_SPARSE_COUNT,
            P_SPARSE_POS:   return dfbd_pkg::IDX_W;
            default:        return dfbd_pkg::BYTE_W;
        endcase
    endfunction

    task automatic clear_parser();
        phase      = P_TYPE;
        shift_reg  = '0;
        field_seen = 0;
        fill_pos   = 0;
        runs_left  = 0;
        target_idx = '0;
    endtask

    task automatic restart_decoder();
        foreach (shown[i])
            shown[i] = '0;
        foreach (delta[i])
            delta[i] = '0;
        clear_parser();
        bits_taken = '0;
    endtask

    // Add the difference to the last frame and queue all 32 bytes
    task automatic emit_frame_bytes();
        frame_byte_t fb;
        for (int i = 0; i < dfbd_pkg::FRAME_BYTES; i++)
        begin
            fb.value   = shown[i] + delta[i];
            fb.idx     = i[dfbd_pkg::IDX_W-1:0];
            fb.is_last = (i == dfbd_pkg::FRAME_BYTES - 1);
            fb.status  = dfbd_pkg::ST_FRAME;
            shown[i]   = fb.value;
            frame_bytes_due.push_back(fb);
        end
        clear_parser();
    endtask

    // One payload bit through the field parser
    task automatic decode_bit(input logic b);
        logic [dfbd_pkg::BYTE_W-1:0] field;
        logic                        done;
        frame_byte_t                 fb;
        if (bits_taken >= bit_budget)
            return;
        done       = 1'b0;
        bits_taken = bits_taken + 1;
        shift_reg  = {shift_reg[dfbd_pkg::BYTE_W-2:0], b};
        field_seen++;
        if (field_seen >= field_width(phase))
        begin
            field      = shift_reg;
            shift_reg  = '0;
            field_seen = 0;
            case (phase)
                P_TYPE:
                begin
                    foreach (delta[i])
                        delta[i] = '0;
                    fill_pos = 0;
                    case (field[1:0])
                        dfbd_pkg::FT_REPEAT: done  = 1'b1;
                        dfbd_pkg::FT_RLE:    phase = P_RUN_COUNT;
                        dfbd_pkg::FT_INDEX:  phase = P_SPARSE_COUNT;
                        default:             phase = P_PLAIN;
                    endcase
                end
                P_RUN_COUNT:
                begin
                    runs_left = field[dfbd_pkg::IDX_W-1:0] + 1;
                    phase     = P_RUN_BYTE;
                end
                P_RUN_BYTE:
                begin
                    // bytes past the frame end are clipped
                    for (int k = 0; k < runs_left && fill_pos < dfbd_pkg::FRAME_BYTES; k++)
                    begin
                        delta[fill_pos] = field;
                        fill_pos++;
                    end
                    if (fill_pos >= dfbd_pkg::FRAME_BYTES)
                        done = 1'b1;
                    else
                        phase = P_RUN_COUNT;
                end
                P_SPARSE_COUNT:
                begin
                    runs_left = field[dfbd_pkg::IDX_W-1:0] + 1;
                    phase     = P_SPARSE_POS;
                end
                P_SPARSE_POS:
                begin
                    target_idx = field[dfbd_pkg::IDX_W-1:0];
                    phase      = P_SPARSE_BYTE;
                end
                P_SPARSE_BYTE:
                begin
                    // a repeated index simply overwrites
                    delta[target_idx] = field;
                    if (runs_left > 0)
                        runs_left--;
                    if (runs_left == 0)
                        done = 1'b1;
                    else
                        phase = P_SPARSE_POS;
                end
                default:
                begin
                    if (fill_pos < dfbd_pkg::FRAME_BYTES)
                    begin
                        delta[fill_pos] = field;
                        fill_pos++;
                    end
                    if (fill_pos >= dfbd_pkg::FRAME_BYTES)
                        done = 1'b1;
                end
            endcase
        end

        if (done)
            emit_frame_bytes();
        else if (bits_taken == bit_budget && (phase != P_TYPE || field_seen != 0))
        begin
            // stream ran out inside a frame
            clear_parser();
            fb.value   = '0;
            fb.idx     = '0;
            fb.is_last = 1'b1;
            fb.status  = dfbd_pkg::ST_TRUNC;
            frame_bytes_due.push_back(fb);
        end
    endtask

    task automatic check_result();
        frame_byte_t want;
        if (frame_bytes_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result value %0h index %0d status %0b",
                out_mon.byte_value, out_mon.byte_index, out_mon.status));
            return;
        end
        want = frame_bytes_due.pop_front();
        if (out_mon.byte_value !== want.value)
            report_mismatch($sformatf("byte_value %0h, expected %0h (index %0d)",
                out_mon.byte_value, want.value, want.idx));
        if (out_mon.byte_index !== want.idx)
            report_mismatch($sformatf("byte_index %0d, expected %0d",
                out_mon.byte_index, want.idx));
        if (out_mon.frame_last !== want.is_last)
            report_mismatch($sformatf("frame_last %0b, expected %0b (index %0d)",
                out_mon.frame_last, want.is_last, want.idx));
        if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0b, expected %0b (index %0d)",
                out_mon.status, want.status, want.idx));
    endtask

    // Results first, so a result never matches an expectation made at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            bit_budget = '0;
            frame_bytes_due.delete();
            restart_decoder();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                check_result();
            if (psel && penable && pwrite && pready && paddr == TOTAL_ADDR)
                bit_budget = pwdata;
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.req_type == dfbd_pkg::REQ_RESTART)
                    restart_decoder();
                else
                    decode_bit(in_mon.stream_bit);
            end
        end
        pending = frame_bytes_due.size();
    end

endmodule

// ===== tb/tb_delta_frame_bit_decoder_core.sv =====
// Testbench top for the delta frame bit decoder: clock, reset, APB writes of the bit
// total, directed and random frame streams, random stalls, and the verdict.
// Depends on dfbd_pkg, dfbd_stream_if, the core RTL and dfbd_frame_checker.
module tb_delta_frame_bit_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dfbd_pkg::APB_ADDR_W-1:0] TOTAL_ADDR = {dfbd_pkg::REG_TOTAL_BITS, 2'b00};
    localparam int RANDOM_ITEMS = 120;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 200000;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dfbd_pkg::APB_ADDR_W-1:0] paddr;
    logic [dfbd_pkg::APB_DATA_W-1:0] pwdata;
    logic [dfbd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int                    fail_count;
    int                    pending;
    int                    items_sent;
    int                    cycle_count;
    logic                  calm;

    dfbd_in_if  in_ch ();
    dfbd_out_if out_ch ();

    delta_frame_bit_decoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    dfbd_frame_checker frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit
    initial
        cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** delta_frame_bit_decoder_core: FAILED **");
        $finish;
    end

    function automatic logic take_break();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    // Output side: random backpressure, changed at the falling edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = rst_n && !take_break();
        end
    end

    // All stimulus tasks start and end just after a falling edge
    task automatic send_item(input logic req, input logic b);
        while (take_break())
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.req_type   = req;
        in_ch.stream_bit = b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Field bits, most significant first
    task automatic send_field(input logic [7:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
            send_item(dfbd_pkg::REQ_BIT, value[i]);
    endtask

    task automatic write_total(input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TOTAL_ADDR;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain all expected results, then let the block finish internal work
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic send_plain(input logic extremes);
        logic [7:0] b;
        send_field(dfbd_pkg::FT_PLAIN, 2);
        for (int i = 0; i < dfbd_pkg::FRAME_BYTES; i++)
        begin
            if (!extremes)
                b = $urandom_range(0, 255);
            else
                case (i % 4)
                    0:       b = 8'hFF;
                    1:       b = 8'h00;
                    2:       b = 8'h80;
                    default: b = 8'h7F;
                endcase
            send_field(b, dfbd_pkg::BYTE_W);
        end
    endtask

    task automatic send_runs();
        int filled;
        int cnt;
        send_field(dfbd_pkg::FT_RLE, 2);
        filled = 0;
        while (filled < dfbd_pkg::FRAME_BYTES)
        begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
            send_field(cnt, dfbd_pkg::IDX_W);
            send_field($urandom_range(0, 255), dfbd_pkg::BYTE_W);
            filled += cnt + 1;
        end
    endtask

    task automatic send_sparse();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
        send_field(dfbd_pkg::FT_INDEX, 2);
        send_field(n - 1, dfbd_pkg::IDX_W);
        repeat (n)
        begin
            send_field($urandom_range(0, 31), dfbd_pkg::IDX_W);
            send_field($urandom_range(0, 255), dfbd_pkg::BYTE_W);
        end
    endtask

    // Mostly well-formed frames with random content, some noise and aborted frames
    task automatic send_random_traffic(input int n_items, input logic with_calm);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            calm = with_calm && (items_sent - start >= n_items / 3) &&
                   (items_sent - start < 2 * n_items / 3);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_field(dfbd_pkg::FT_REPEAT, 2);
            else if (pick < 47)
                send_runs();
            else if (pick < 80)
                send_sparse();
            else if (pick < 84)
                send_plain(1'b0);
            else if (pick < 91)
                repeat ($urandom_range(1, 12))
                    send_item(dfbd_pkg::REQ_BIT, $urandom_range(0, 1));
            else if (pick < 97)
            begin
                send_field($urandom_range(0, 3), 2);
                repeat ($urandom_range(1, 20))
                    send_item(dfbd_pkg::REQ_BIT, $urandom_range(0, 1));
                send_item(dfbd_pkg::REQ_RESTART, $urandom_range(0, 1));
            end
            else
                send_item(dfbd_pkg::REQ_RESTART, $urandom_range(0, 1));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = dfbd_pkg::REQ_BIT;
        in_ch.stream_bit = 1'b0;
        calm             = 1'b0;
        items_sent       = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero total: every bit dropped
        write_total(32'h0000_0000);
        send_item(dfbd_pkg::REQ_BIT, 1'b1);
        send_item(dfbd_pkg::REQ_BIT, 1'b0);
        send_item(dfbd_pkg::REQ_BIT, 1'b1);
        send_item(dfbd_pkg::REQ_RESTART, 1'b0);
        wait_idle();
        write_total(32'hFFFF_FFFF);

        // Each frame type, extreme bytes, wraparound of the sum
        send_field(dfbd_pkg::FT_REPEAT, 2);
        send_plain(1'b1);
        send_field(dfbd_pkg::FT_RLE, 2);
        send_field(31, dfbd_pkg::IDX_W);
        send_field(8'hFF, dfbd_pkg::BYTE_W);
        // run overflow: second run clipped at the frame end
        send_field(dfbd_pkg::FT_RLE, 2);
        send_field(20, dfbd_pkg::IDX_W);
        send_field(8'h55, dfbd_pkg::BYTE_W);
        send_field(31, dfbd_pkg::IDX_W);
        send_field(8'hAA, dfbd_pkg::BYTE_W);
        send_field(dfbd_pkg::FT_INDEX, 2);
        send_field(0, dfbd_pkg::IDX_W);
        send_field(31, dfbd_pkg::IDX_W);
        send_field(8'hFF, dfbd_pkg::BYTE_W);
        // duplicate index: later entry wins
        send_field(dfbd_pkg::FT_INDEX, 2);
        send_field(2, dfbd_pkg::IDX_W);
        send_field(5, dfbd_pkg::IDX_W);
        send_field(8'h01, dfbd_pkg::BYTE_W);
        send_field(5, dfbd_pkg::IDX_W);
        send_field(8'h02, dfbd_pkg::BYTE_W);
        send_field(0, dfbd_pkg::IDX_W);
        send_field(8'h80, dfbd_pkg::BYTE_W);
        // restart inside a frame clears the last frame
        send_field(dfbd_pkg::FT_PLAIN, 2);
        send_field(5'h13, 5);
        send_item(dfbd_pkg::REQ_RESTART, 1'b1);
        send_field(dfbd_pkg::FT_REPEAT, 2);

        // Lowered total drops bits, then truncation inside the type field
        wait_idle();
        write_total(32'd1);
        send_field(4'hA, 4);
        send_item(dfbd_pkg::REQ_RESTART, 1'b0);
        send_item(dfbd_pkg::REQ_BIT, 1'b1);
        send_field(2'b11, 2);
        // raised total: parsing resumes with a new type field, truncated in a run
        wait_idle();
        write_total(32'd10);
        send_field(dfbd_pkg::FT_REPEAT, 2);
        send_field(dfbd_pkg::FT_RLE, 2);
        send_field(7, dfbd_pkg::IDX_W);
        send_item(dfbd_pkg::REQ_BIT, 1'b0);
        // stream ends exactly on a frame end: no truncation
        send_item(dfbd_pkg::REQ_RESTART, 1'b0);
        wait_idle();
        write_total(32'd15);
        send_field(dfbd_pkg::FT_RLE, 2);
        send_field(31, dfbd_pkg::IDX_W);
        send_field(8'h3C, dfbd_pkg::BYTE_W);
        send_item(dfbd_pkg::REQ_BIT, 1'b1);
        // ends right after a type field
        send_item(dfbd_pkg::REQ_RESTART, 1'b1);
        wait_idle();
        write_total(32'd2);
        send_field(dfbd_pkg::FT_PLAIN, 2);
        wait_idle();
        write_total(32'hFFFF_FFFF);

        // Random streams with unlimited total
        send_random_traffic(RANDOM_ITEMS, 1'b1);

        // Random streams that run out of bits
        repeat (3)
        begin
            int budget;
            send_item(dfbd_pkg::REQ_RESTART, $urandom_range(0, 1));
            wait_idle();
            budget = $urandom_range(1, 30);
            write_total(budget);
            send_random_traffic(budget + 4, 1'b0);
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("** delta_frame_bit_decoder_core: PASSED **");
        else
            $display("** delta_frame_bit_decoder_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dfbd_pkg.sv
sv/dfbd_stream_if.sv
sv/dfbd_ram.sv
sv/dfbd_apb.sv
sv/dfbd_parser.sv
sv/dfbd_emitter.sv
sv/delta_frame_bit_decoder_core.sv
sv/dfbd_checker.sv
tb/dfbd_frame_checker.sv
tb/tb_delta_frame_bit_decoder_core.sv
